### src/pwsd_pkg.sv
// Shared types and constants for the work-stealing job dispatcher.
// No dependencies; imported by pwsd_front, pwsd_back and the top level.
`default_nettype none
package pwsd_pkg;

  localparam int NUM_WORKERS     = 8;
  localparam int PRIO_LEVELS     = 3;
  localparam int NUM_GROUPS      = 16;
  localparam int TAG_W           = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CNT_W           = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [3:0] WORKER_COUNT_RST = 4'd8;
  localparam logic [1:0] PRIO_NORMAL = 2'd1;

  typedef enum logic [1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_TAKE     = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_POP  = 2'd2,
    S_READ = 2'd3
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  prio;
    logic [TAG_W-1:0] tag;
    logic        in_group;
    logic [3:0]  gid;
    logic [2:0]  widx;
    logic        ext;
    logic        failed;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [TAG_W-1:0] tag;
    logic        in_group;
    logic [3:0]  group;
    logic [1:0]  prio;
    logic        stolen;
    logic [2:0]  src;
    logic [CNT_W-1:0] gcount;
    logic        gerr;
    logic        gdone;
    logic [CNT_W-1:0] outst;
    logic        idle;
  } res_t;

  // Stored job: tag, group flag, group
  localparam int JOB_W = TAG_W + 1 + 4;

endpackage
`default_nettype wire

### src/pwsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pwsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/pwsd_front.sv
// Front end: accepts requests into a two-entry queue, normalises the
// priority and holds the worker_count register. Uses pwsd_pkg.
`default_nettype none
module pwsd_front import pwsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire req_t       in_req,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data,
  output logic            q_valid,
  input  wire logic       q_ready,
  output req_t            q_req,
  output logic [3:0]      active_n
);
  req_t        slot [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fill;
  logic [3:0]  worker_count;
  logic        push, pop;
  req_t        norm;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (fill == 2'd2);
  assign push      = in_valid && !in_stall;
  assign q_valid   = (fill != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_req     = slot[rd_ptr];

  always_comb begin
    norm = in_req;
    if (in_req.prio >= 2'(PRIO_LEVELS)) begin
      norm.prio = (PRIO_LEVELS > 1) ? PRIO_NORMAL : 2'd0;
    end
  end

  always_comb begin
    if (worker_count == 4'd0) begin
      active_n = 4'd1;
    end else if (worker_count > 4'(NUM_WORKERS)) begin
      active_n = 4'(NUM_WORKERS);
    end else begin
      active_n = worker_count;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= norm;
    end
    if (rst) begin
      wr_ptr       <= 1'b0;
      rd_ptr       <= 1'b0;
      fill         <= 2'd0;
      worker_count <= WORKER_COUNT_RST;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
      if (cfg_valid && cfg_ready) worker_count <= cfg_data;
    end
  end
endmodule
`default_nettype wire

### src/pwsd_back.sv
// Back end: deque bookkeeping, victim scan, job store and group counters.
// Uses pwsd_pkg and pwsd_ram.
`default_nettype none
module pwsd_back import pwsd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  wire req_t       q_req,
  input  wire logic [3:0] active_n,
  output logic            res_valid,
  input  wire logic       res_stall,
  output res_t            res
);
  localparam int NQ  = NUM_WORKERS * PRIO_LEVELS;
  localparam int QIW = $clog2(NQ);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SD  = NQ * QUEUE_DEPTH;
  localparam int AW  = $clog2(SD);

  state_t state, state_next;

  logic [QW-1:0]    head [NQ];
  logic [FW-1:0]    fill [NQ];
  logic [2:0]       next_worker;
  logic [CNT_W-1:0] outst;
  logic [CNT_W-1:0] grem [NUM_GROUPS];
  logic             gfail [NUM_GROUPS];

  req_t             cur;
  logic [QIW-1:0]   qsel;
  logic             from_back;
  logic [2:0]       src;
  logic [1:0]       prio;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [JOB_W-1:0] wdata, rdata;

  // scan result
  logic             s_got, s_back;
  logic [QIW-1:0]   s_q;
  logic [2:0]       s_src;
  logic [1:0]       s_prio;
  logic             own_ok;

  // submit target
  logic [2:0]       sw;
  logic [QIW-1:0]   sq;
  logic [FW:0]      ssum;
  logic [QW-1:0]    spos;

  // pop position
  logic [FW:0]      psum;
  logic [QW-1:0]    ppos;

  logic [3:0]       rg;

  // saturating counter steps
  logic [CNT_W-1:0] outst_inc, outst_dec;
  logic [CNT_W-1:0] grem_cur, grem_inc, grem_dec;
  logic             gfail_cur;

  res_t             res_next;

  assign q_ready = (state == S_IDLE) && !res_valid;

  always_comb begin
    own_ok = !cur.ext && ({1'b0, cur.widx} < active_n);
    s_got  = 1'b0;
    s_back = 1'b0;
    s_q    = '0;
    s_src  = '0;
    s_prio = '0;
    for (int p = 0; p < PRIO_LEVELS; p++) begin
      if (!s_got && own_ok && fill[QIW'(int'(cur.widx) * PRIO_LEVELS + p)] != '0) begin
        s_got  = 1'b1;
        s_back = 1'b1;
        s_q    = QIW'(int'(cur.widx) * PRIO_LEVELS + p);
        s_src  = cur.widx;
        s_prio = 2'(p);
      end
    end
    for (int v = 0; v < NUM_WORKERS; v++) begin
      for (int p = 0; p < PRIO_LEVELS; p++) begin
        if (!s_got && (v < int'(active_n)) && !(!cur.ext && v == int'(cur.widx))
            && fill[QIW'(v * PRIO_LEVELS + p)] != '0) begin
          s_got  = 1'b1;
          s_q    = QIW'(v * PRIO_LEVELS + p);
          s_src  = 3'(v);
          s_prio = 2'(p);
        end
      end
    end
  end

  always_comb begin
    sw   = ({1'b0, next_worker} < active_n) ? next_worker : 3'd0;
    sq   = QIW'(int'(sw) * PRIO_LEVELS + int'(cur.prio));
    ssum = (FW+1)'(head[sq]) + (FW+1)'(fill[sq]);
    if (ssum >= (FW+1)'(QUEUE_DEPTH)) ssum = ssum - (FW+1)'(QUEUE_DEPTH);
    spos = QW'(ssum);
    psum = (FW+1)'(head[qsel]) + (FW+1)'(fill[qsel]) - (FW+1)'(1);
    if (psum >= (FW+1)'(QUEUE_DEPTH)) psum = psum - (FW+1)'(QUEUE_DEPTH);
    ppos = from_back ? QW'(psum) : head[qsel];
  end

  assign we    = (state == S_EXEC) && (cur.cmd == CMD_SUBMIT)
                 && (fill[sq] != FW'(QUEUE_DEPTH));
  assign waddr = AW'(int'(sq) * QUEUE_DEPTH + int'(spos));
  assign wdata = {cur.tag, cur.in_group, cur.gid};
  assign raddr = AW'(int'(qsel) * QUEUE_DEPTH + int'(ppos));
  assign rg    = rdata[3:0];

  assign outst_inc = (outst == CNT_MAX) ? outst : outst + CNT_W'(1);
  assign outst_dec = (outst == '0) ? '0 : outst - CNT_W'(1);
  assign grem_cur  = grem[cur.gid];
  assign gfail_cur = gfail[cur.gid];
  assign grem_inc  = (grem_cur == CNT_MAX) ? CNT_MAX : grem_cur + CNT_W'(1);
  assign grem_dec  = (grem_cur == '0) ? '0 : grem_cur - CNT_W'(1);

  pwsd_ram #(.WIDTH(JOB_W), .DEPTH(SD)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid && q_ready) state_next = S_EXEC;
      S_EXEC: state_next = (cur.cmd == CMD_TAKE && s_got) ? S_POP : S_IDLE;
      S_POP:  state_next = S_READ;
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result word, loaded at the end of the execute or read cycle
  always_comb begin
    res_next       = '0;
    res_next.outst = outst;
    case (state)
      S_EXEC: begin
        case (cur.cmd)
          CMD_SUBMIT: begin
            res_next.src = sw;
            if (cur.in_group) begin
              res_next.gcount = grem_cur;
              res_next.gerr   = gfail_cur;
            end
            if (we) begin
              res_next.outst = outst_inc;
              if (cur.in_group) res_next.gcount = grem_inc;
            end else begin
              res_next.status = ST_FULL;
            end
          end
          CMD_TAKE: begin
            if (!s_got) res_next.status = ST_EMPTY;
          end
          CMD_COMPLETE: begin
            if (cur.in_group) begin
              res_next.gcount = grem_dec;
              res_next.gerr   = cur.failed || gfail_cur;
              res_next.gdone  = (grem_cur == CNT_W'(1));
            end
            res_next.idle  = (outst == CNT_W'(1));
            res_next.outst = outst_dec;
          end
          CMD_QUERY: begin
            res_next.gcount = grem_cur;
            res_next.gerr   = gfail_cur;
          end
          default: ;
        endcase
      end
      S_READ: begin
        res_next.status   = ST_OK;
        res_next.tag      = rdata[JOB_W-1:5];
        res_next.in_group = rdata[4];
        res_next.group    = rg;
        res_next.prio     = prio;
        res_next.stolen   = !from_back;
        res_next.src      = src;
        if (rdata[4]) begin
          res_next.gcount = grem[rg];
          res_next.gerr   = gfail[rg];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur <= q_req;
    end
    if (rst) begin
      res_valid   <= 1'b0;
      next_worker <= '0;
      outst       <= '0;
      for (int i = 0; i < NQ; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
      for (int i = 0; i < NUM_GROUPS; i++) begin
        grem[i]  <= '0;
        gfail[i] <= 1'b0;
      end
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      if (state == S_EXEC || state == S_READ) res <= res_next;
      case (state)
        S_EXEC: begin
          case (cur.cmd)
            CMD_SUBMIT: begin
              res_valid   <= 1'b1;
              next_worker <= ({1'b0, sw} + 4'd1 >= active_n) ? 3'd0 : sw + 3'd1;
              if (we) begin
                fill[sq] <= fill[sq] + FW'(1);
                outst    <= outst_inc;
                if (cur.in_group) grem[cur.gid] <= grem_inc;
              end
            end
            CMD_TAKE: begin
              qsel      <= s_q;
              from_back <= s_back;
              src       <= s_src;
              prio      <= s_prio;
              if (!s_got) res_valid <= 1'b1;
            end
            CMD_COMPLETE: begin
              res_valid <= 1'b1;
              if (cur.in_group) begin
                if (cur.failed) gfail[cur.gid] <= 1'b1;
                grem[cur.gid] <= grem_dec;
              end
              outst <= outst_dec;
            end
            CMD_QUERY: begin
              res_valid      <= 1'b1;
              gfail[cur.gid] <= 1'b0;
            end
            default: ;
          endcase
        end
        S_POP: begin
          fill[qsel] <= fill[qsel] - FW'(1);
          if (!from_back) begin
            head[qsel] <= (head[qsel] == QW'(QUEUE_DEPTH - 1)) ? '0 : head[qsel] + QW'(1);
          end
        end
        S_READ: begin
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/priority_work_stealing_dispatcher.sv
// Top level of the work-stealing job dispatcher: front queue and back end.
// Uses pwsd_pkg, pwsd_front, pwsd_back.
//
//  channel | dir | handshake        | payload
//  in      | in  | in_valid/stall   | command .. job_failed
//  out     | out | out_valid/stall  | status .. all_idle
//  cfg     | in  | cfg_valid/ready  | cfg_data (worker_count)
//
// Submit, complete and query give their result from the execute state; a take
// goes on through the pop and read states (scan, deque update, job store read)
// because the store's read is registered. One request is worked on at a time
// and the next one enters the back end only after the result has left. The
// front queue holds two more.
// rst is synchronous: deques empty, counters zero, worker_count 8.
// A stalled result holds the back end; the front keeps accepting until full.
`default_nettype none
module priority_work_stealing_dispatcher import pwsd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [1:0]  priority_req,
  input  wire logic [15:0] job_tag,
  input  wire logic        in_group,
  input  wire logic [3:0]  group_id,
  input  wire logic [2:0]  worker_index,
  input  wire logic        external,
  input  wire logic        job_failed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [15:0]      taken_tag,
  output logic             taken_in_group,
  output logic [3:0]       taken_group,
  output logic [1:0]       taken_priority,
  output logic             stolen,
  output logic [2:0]       source_worker,
  output logic [8:0]       group_count,
  output logic             group_error,
  output logic             group_done,
  output logic [8:0]       outstanding,
  output logic             all_idle,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);
  req_t       in_req, q_req;
  res_t       res;
  logic       q_valid, q_ready;
  logic [3:0] active_n;

  always_comb begin
    in_req.cmd      = cmd_t'(command);
    in_req.prio     = priority_req;
    in_req.tag      = job_tag;
    in_req.in_group = in_group;
    in_req.gid      = group_id;
    in_req.widx     = worker_index;
    in_req.ext      = external;
    in_req.failed   = job_failed;
  end

  pwsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .active_n  (active_n)
  );

  pwsd_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .active_n  (active_n),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  assign status         = res.status;
  assign taken_tag      = res.tag;
  assign taken_in_group = res.in_group;
  assign taken_group    = res.group;
  assign taken_priority = res.prio;
  assign stolen         = res.stolen;
  assign source_worker  = res.src;
  assign group_count    = res.gcount;
  assign group_error    = res.gerr;
  assign group_done     = res.gdone;
  assign outstanding    = res.outst;
  assign all_idle       = res.idle;
endmodule
`default_nettype wire

### src/pwsd_checker.sv
// Port-level checks for the dispatcher, bound to the top level.
// Uses only the top level's ports.
`default_nettype none
module pwsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [15:0] taken_tag,
  input wire logic        stolen,
  input wire logic [2:0]  source_worker,
  input wire logic        group_done,
  input wire logic        all_idle,
  input wire logic [8:0]  outstanding
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(taken_tag) && $stable(status))
    else $error("stalled result changed");

  a_empty_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == 2'd2 |-> taken_tag == 16'd0 && !stolen && source_worker == 3'd0)
    else $error("empty take carries job fields");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 2'd0 |-> !group_done && !all_idle)
    else $error("completion flag on failed request");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && all_idle |-> outstanding == 9'd0)
    else $error("all_idle with jobs outstanding");
endmodule

bind priority_work_stealing_dispatcher pwsd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .taken_tag     (taken_tag),
  .stolen        (stolen),
  .source_worker (source_worker),
  .group_done    (group_done),
  .all_idle      (all_idle),
  .outstanding   (outstanding)
);
`default_nettype wire
